>>> hw/rtl/brlt_pkg.sv
// Shared types and constants for the bucketed ring lookup table.
package brlt_pkg;

  // Field widths of the request and result items.
  localparam int KEY_W = 17;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;
  // Bucket number of any 17-bit key (up to 13) fits in four bits.
  localparam int BKT_W = 4;

  // Keys per bucket.
  localparam logic [KEY_W-1:0] KEY_SPAN = 17'd10000;

  // Request opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  // Flags and difference from the shared compare-subtract unit.
  typedef struct packed {
    logic             eq;
    logic             ge;
    logic [KEY_W-1:0] diff;
  } alu_res_t;

endpackage

>>> hw/rtl/brlt_if.sv
// Request and result channel interfaces with valid/ready handshake.
interface brlt_in_if;
  import brlt_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] product_key;
  logic [CNT_W-1:0] stock_count;

  modport source(output valid, output opcode, output product_key, output stock_count,
                 input ready);
  modport sink(input valid, input opcode, input product_key, input stock_count,
               output ready);
endinterface

interface brlt_out_if;
  import brlt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] found_count;
  logic [KEY_W-1:0] next_key;
  logic [KEY_W-1:0] prev_key;

  modport source(output valid, output status, output found_count, output next_key,
                 output prev_key, input ready);
  modport sink(input valid, input status, input found_count, input next_key,
               input prev_key, output ready);
endinterface

>>> hw/rtl/bucketed_ring_lookup_table_core.sv
// Top level of the bucketed ring lookup table: sequencer, bucket state and result register.
//
// Each request is worked on alone. The bucket (key / 10000) is found first by repeated
// compare-subtract on the shared unit, one step per cycle; S_LOOKUP then reads the bucket's
// fill and head. An insert moves each slot from head to fill-1 up by one through the entry
// memory, reading it in S_SH_RD and writing it in S_SH_WR, then writes the new entry in
// S_INS_WR. A search reads and compares one ring entry at a time from the head on, in S_SR_RD
// and S_SR_CMP, and a hit reads the neighbor keys in S_HIT_NX and S_HIT_PV. S_DONE hands the
// result to the output register, and the next request is taken while that result waits.
// The store needs no clearing pass after reset.
module bucketed_ring_lookup_table_core #(
  parameter int BUCKETS    = 10,
  parameter int RING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  brlt_in_if.sink    in_req,
  brlt_out_if.source out_rsp
);
  import brlt_pkg::*;

  localparam int DEPTH = BUCKETS * RING_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int HW    = $clog2(RING_DEPTH);
  localparam int BIW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DW    = KEY_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LOOKUP,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_SR_RD,
    S_SR_CMP,
    S_HIT_NX,
    S_HIT_PV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Request registers.
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Bucket division registers.
  logic [KEY_W-1:0] rem_r, rem_nxt;
  logic [BKT_W-1:0] bkt_r, bkt_nxt;
  logic [AW-1:0]    base_r, base_nxt;

  // Ring walk registers.
  logic [FW-1:0]    n_r, n_nxt;
  logic [HW-1:0]    h_r, h_nxt;
  logic [FW-1:0]    idx_r, idx_nxt;
  logic [HW-1:0]    pos_r, pos_nxt;
  logic [FW-1:0]    step_r, step_nxt;
  logic [HW-1:0]    pv_r, pv_nxt;

  // Result being built, and the output register.
  status_t          res_status_r, res_status_nxt;
  logic [CNT_W-1:0] res_count_r, res_count_nxt;
  logic [KEY_W-1:0] res_next_r, res_next_nxt;
  logic [KEY_W-1:0] res_prev_r, res_prev_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic [KEY_W-1:0] out_next_r, out_next_nxt;
  logic [KEY_W-1:0] out_prev_r, out_prev_nxt;

  // Per-bucket fill and head.
  logic [FW-1:0] fill_r [BUCKETS];
  logic [HW-1:0] head_r [BUCKETS];
  logic          fill_we, head_we;
  logic [FW-1:0] fill_wdata;
  logic [HW-1:0] head_wdata;

  // Memory and shared unit hookup.
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] rd_cnt;
  logic [KEY_W-1:0] alu_a, alu_b;
  alu_res_t         alu_res;

  logic [BIW-1:0] bi;
  logic           in_range;
  logic [FW-1:0]  fill_cur;
  logic [HW-1:0]  head_cur;
  logic [HW-1:0]  nx_pos;
  logic           out_load;

  assign bi       = bkt_r[BIW-1:0];
  assign in_range = (bkt_r < BKT_W'(BUCKETS));
  assign fill_cur = fill_r[bi];
  assign head_cur = head_r[bi];
  assign rd_key   = rd_data[DW-1:CNT_W];
  assign rd_cnt   = rd_data[CNT_W-1:0];

  // Ring successor of the probed position.
  assign nx_pos = ((FW'(pos_r) + FW'(1)) == n_r) ? '0 : (pos_r + HW'(1));

  // Shared unit: divides during S_DIV, matches keys otherwise.
  assign alu_a = (state_r == S_DIV) ? rem_r : rd_key;
  assign alu_b = (state_r == S_DIV) ? KEY_SPAN : key_r;

  brlt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  brlt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    bkt_nxt        = bkt_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    h_nxt          = h_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    pv_nxt         = pv_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_next_nxt   = res_next_r;
    res_prev_nxt   = res_prev_r;
    fill_we        = 1'b0;
    head_we        = 1'b0;
    fill_wdata     = n_r + FW'(1);
    head_wdata     = h_r;
    wr_en          = 1'b0;
    wr_addr        = base_r + AW'(idx_r);
    wr_data        = rd_data;
    rd_addr        = base_r + AW'(pos_r);
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt         = in_req.opcode;
          key_nxt        = in_req.product_key;
          cnt_nxt        = in_req.stock_count;
          rem_nxt        = in_req.product_key;
          bkt_nxt        = '0;
          base_nxt       = '0;
          res_status_nxt = ST_MISSING;
          res_count_nxt  = '0;
          res_next_nxt   = '0;
          res_prev_nxt   = '0;
          state_nxt      = S_DIV;
        end
      end
      // One subtraction of the bucket span per cycle.
      S_DIV: begin
        if (alu_res.ge) begin
          rem_nxt  = alu_res.diff;
          bkt_nxt  = bkt_r + BKT_W'(1);
          base_nxt = base_r + AW'(RING_DEPTH);
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      // Read the bucket's fill and head and pick the operation path.
      S_LOOKUP: begin
        n_nxt = fill_cur;
        if (op_r == OP_INSERT) begin
          if (!in_range || fill_cur == FW'(RING_DEPTH)) begin
            res_status_nxt = ST_REJECTED;
            state_nxt      = S_DONE;
          end else begin
            h_nxt     = (FW'(head_cur) > fill_cur) ? '0 : head_cur;
            idx_nxt   = fill_cur;
            state_nxt = (fill_cur > FW'(h_nxt)) ? S_SH_RD : S_INS_WR;
          end
        end else begin
          if (!in_range || fill_cur == '0) begin
            res_status_nxt = ST_MISSING;
            state_nxt      = S_DONE;
          end else begin
            pos_nxt   = (FW'(head_cur) >= fill_cur) ? '0 : head_cur;
            step_nxt  = '0;
            state_nxt = S_SR_RD;
          end
        end
      end
      // Move the slot below idx up into idx.
      S_SH_RD: begin
        rd_addr   = base_r + AW'(idx_r - FW'(1));
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - FW'(1);
        state_nxt = (idx_nxt > FW'(h_r)) ? S_SH_RD : S_INS_WR;
      end
      // Write the new entry at the head slot.
      S_INS_WR: begin
        wr_en          = 1'b1;
        wr_addr        = base_r + AW'(h_r);
        wr_data        = {key_r, cnt_r};
        fill_we        = 1'b1;
        head_we        = 1'b1;
        res_status_nxt = ST_INSERTED;
        state_nxt      = S_DONE;
      end
      // Probe the ring from the head toward successors.
      S_SR_RD: begin
        state_nxt = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (alu_res.eq) begin
          head_we       = 1'b1;
          head_wdata    = pos_r;
          res_count_nxt = rd_cnt;
          pv_nxt        = (pos_r == '0) ? HW'(n_r - FW'(1)) : (pos_r - HW'(1));
          rd_addr       = base_r + AW'(nx_pos);
          state_nxt     = S_HIT_NX;
        end else if ((step_r + FW'(1)) == n_r) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_DONE;
        end else begin
          step_nxt  = step_r + FW'(1);
          pos_nxt   = nx_pos;
          state_nxt = S_SR_RD;
        end
      end
      // Collect the neighbor keys of the hit.
      S_HIT_NX: begin
        res_next_nxt = rd_key;
        rd_addr      = base_r + AW'(pv_r);
        state_nxt    = S_HIT_PV;
      end
      S_HIT_PV: begin
        res_prev_nxt   = rd_key;
        res_status_nxt = ST_FOUND;
        state_nxt      = S_DONE;
      end
      // Hand the result over once the output register is free.
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = out_load | (out_valid_r & ~out_rsp.ready);
    out_status_nxt = out_load ? res_status_r : out_status_r;
    out_count_nxt  = out_load ? res_count_r : out_count_r;
    out_next_nxt   = out_load ? res_next_r : out_next_r;
    out_prev_nxt   = out_load ? res_prev_r : out_prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fill_we) begin
        fill_r[bi] <= fill_wdata;
      end
      if (head_we) begin
        head_r[bi] <= head_wdata;
      end
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    bkt_r        <= bkt_nxt;
    base_r       <= base_nxt;
    n_r          <= n_nxt;
    h_r          <= h_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    pv_r         <= pv_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_next_r   <= res_next_nxt;
    res_prev_r   <= res_prev_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_next_r   <= out_next_nxt;
    out_prev_r   <= out_prev_nxt;
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found_count = out_count_r;
  assign out_rsp.next_key    = out_next_r;
  assign out_rsp.prev_key    = out_prev_r;

`ifndef ASSERT_OFF
  // A bucket in range never holds more entries than a ring has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP && in_range) |-> (fill_cur <= FW'(RING_DEPTH)))
    else $error("bucket fill exceeds ring depth");

  // Slot moves stay between the head and the old fill.
  a_shift_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> (idx_r > FW'(h_r) && idx_r <= n_r))
    else $error("ring shift outside head..fill");

  // The search never probes past the occupied slots.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SR_CMP) |-> (step_r < n_r && FW'(pos_r) < n_r))
    else $error("search probe out of ring");

  // A result appears only out of the handover state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside handover");

  // A stalled result is never overwritten by the next one.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule

>>> hw/rtl/brlt_alu.sv
// Shared compare-subtract unit for bucket division and key matching.
module brlt_alu (
  input  logic [brlt_pkg::KEY_W-1:0] a,
  input  logic [brlt_pkg::KEY_W-1:0] b,
  output brlt_pkg::alu_res_t         res
);
  import brlt_pkg::*;

  logic [KEY_W:0] sub;

  // One subtract gives the difference, and its borrow gives the ordering.
  assign sub      = {1'b0, a} - {1'b0, b};
  assign res.diff = sub[KEY_W-1:0];
  assign res.ge   = ~sub[KEY_W];
  assign res.eq   = (a == b);

endmodule

>>> hw/rtl/brlt_mem.sv
// Entry store: one write port and one registered read port.
module brlt_mem #(
  parameter int DEPTH = 160,
  parameter int AW    = 8,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, data available the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sim/lookup_result_checker.sv
// Checker that predicts and compares every response of the bucketed ring lookup table.
module lookup_result_checker
  import brlt_pkg::*;
#(
  parameter int BUCKETS    = 10,
  parameter int RING_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  brlt_in_if    in_mon,
  brlt_out_if   out_mon,
  output int    fail_count,
  output int    pending_count
);

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] found_count;
    logic [KEY_W-1:0] next_key;
    logic [KEY_W-1:0] prev_key;
  } lookup_rsp_t;

  // Shadow copy of the table: per-bucket rings, fill levels and heads.
  logic [KEY_W-1:0] ring_keys   [BUCKETS][RING_DEPTH];
  logic [CNT_W-1:0] ring_counts [BUCKETS][RING_DEPTH];
  int               ring_fill   [BUCKETS];
  int               ring_head   [BUCKETS];

  lookup_rsp_t pending_responses[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int b = 0; b < BUCKETS; b++) begin
      ring_fill[b] = 0;
      ring_head[b] = 0;
    end
  end

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic lookup_rsp_t apply_table_request(logic op, logic [KEY_W-1:0] key,
                                                      logic [CNT_W-1:0] cnt);
    lookup_rsp_t rsp;
    int          bkt;
    int          n;
    int          h;
    int          i;
    int          pos;
    rsp.status      = ST_MISSING;
    rsp.found_count = '0;
    rsp.next_key    = '0;
    rsp.prev_key    = '0;
    bkt = int'(key / KEY_SPAN);
    if (op == OP_INSERT) begin
      if (bkt >= BUCKETS || ring_fill[bkt] >= RING_DEPTH) begin
        rsp.status = ST_REJECTED;
      end else begin
        n = ring_fill[bkt];
        h = ring_head[bkt];
        if (h > n) h = 0;
        // Open a slot at the head by moving the later entries up by one.
        for (i = n; i > h; i--) begin
          ring_keys[bkt][i]   = ring_keys[bkt][i-1];
          ring_counts[bkt][i] = ring_counts[bkt][i-1];
        end
        ring_keys[bkt][h]   = key;
        ring_counts[bkt][h] = cnt;
        ring_head[bkt]      = h;
        ring_fill[bkt]      = n + 1;
        rsp.status          = ST_INSERTED;
      end
    end else if (bkt < BUCKETS && ring_fill[bkt] > 0) begin
      n = ring_fill[bkt];
      h = ring_head[bkt];
      if (h >= n) h = 0;
      // Walk from the head towards successors; the first match wins and becomes the head.
      for (i = 0; i < n; i++) begin
        pos = (h + i) % n;
        if (ring_keys[bkt][pos] == key) begin
          ring_head[bkt]  = pos;
          rsp.status      = ST_FOUND;
          rsp.found_count = ring_counts[bkt][pos];
          rsp.next_key    = ring_keys[bkt][(pos + 1) % n];
          rsp.prev_key    = ring_keys[bkt][(pos + n - 1) % n];
          break;
        end
      end
    end
    return rsp;
  endfunction

  // Compare each delivered response first, then record the request taken at the same edge.
  always @(posedge clk) begin
    lookup_rsp_t exp_rsp;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_responses.size() == 0) begin
          $error("Response with status %0d arrived with no request outstanding",
                 out_mon.status);
          fail_count++;
        end else begin
          exp_rsp = pending_responses.pop_front();
          if (out_mon.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_mon.status);
            fail_count++;
          end
          if (out_mon.found_count !== exp_rsp.found_count) begin
            $error("found_count: expected %0d, got %0d", exp_rsp.found_count,
                   out_mon.found_count);
            fail_count++;
          end
          if (out_mon.next_key !== exp_rsp.next_key) begin
            $error("next_key: expected %0d, got %0d", exp_rsp.next_key, out_mon.next_key);
            fail_count++;
          end
          if (out_mon.prev_key !== exp_rsp.prev_key) begin
            $error("prev_key: expected %0d, got %0d", exp_rsp.prev_key, out_mon.prev_key);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_responses.push_back(apply_table_request(in_mon.opcode, in_mon.product_key,
                                                        in_mon.stock_count));
      end
      pending_count = pending_responses.size();
    end
  end

endmodule

>>> sim/bucketed_ring_lookup_table_core_tb.sv
// Testbench top for the bucketed ring lookup table: stimulus, flow control and verdict.
module bucketed_ring_lookup_table_core_tb;
  import brlt_pkg::*;

  localparam int BUCKETS      = 10;
  localparam int RING_DEPTH   = 16;
  localparam int PHASE_ITEMS  = 185;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst_n;

  brlt_in_if  in_req();
  brlt_out_if out_rsp();

  int fail_count;
  int pending_count;
  int cycle_count;

  // Flow control knobs, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_start;

  logic [KEY_W-1:0] inserted_keys[$];

  bucketed_ring_lookup_table_core #(
    .BUCKETS    (BUCKETS),
    .RING_DEPTH (RING_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  lookup_result_checker #(
    .BUCKETS    (BUCKETS),
    .RING_DEPTH (RING_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_req),
    .out_mon       (out_rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Response side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one request from a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.opcode      <= op;
    in_req.product_key <= key;
    in_req.stock_count <= cnt;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
    if (op == OP_INSERT) inserted_keys.push_back(key);
  endtask

  // Mostly keys of valid buckets, with bucket edges and the full 17-bit range mixed in.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(19))
      0, 1, 2: key = KEY_W'($urandom_range(131071));
      3:       key = KEY_W'($urandom_range(9) * 10000 + ($urandom_range(1) ? 9999 : 0));
      default: key = KEY_W'($urandom_range(9) * 10000 + $urandom_range(9999));
    endcase
    return key;
  endfunction

  // One random request: searches lean on keys already inserted so that hits are common.
  task automatic send_random_request();
    logic             op;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'($urandom_range(127));
    if ($urandom_range(99) < 45) begin
      op = OP_INSERT;
      if (inserted_keys.size() > 0 && $urandom_range(9) == 0)
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      else
        key = random_key();
    end else begin
      op = OP_SEARCH;
      if (inserted_keys.size() > 0 && $urandom_range(99) < 70)
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      else
        key = random_key();
    end
    send_request(op, key, cnt);
  endtask

  initial begin
    in_req.valid       = 1'b0;
    in_req.opcode      = OP_INSERT;
    in_req.product_key = '0;
    in_req.stock_count = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_start         = 1'b0;
    rst_n              = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty bucket, single-entry rings and key extremes.
    send_request(OP_SEARCH, 17'd0, 7'd127);
    send_request(OP_INSERT, 17'd0, 7'd0);
    send_request(OP_SEARCH, 17'd0, 7'd0);
    send_request(OP_INSERT, 17'd99999, 7'd127);
    send_request(OP_SEARCH, 17'd99999, 7'd99);
    send_request(OP_SEARCH, 17'd20000, 7'd0);
    // Keys beyond the last bucket are never stored.
    send_request(OP_INSERT, 17'd131071, 7'd99);
    send_request(OP_SEARCH, 17'd131071, 7'd0);
    // Fill one ring completely, then overflow it and search inside the full ring.
    for (int i = 0; i < RING_DEPTH; i++)
      send_request(OP_INSERT, 17'(50000 + i * 17), 7'(i * 8));
    send_request(OP_INSERT, 17'd59999, 7'd1);
    send_request(OP_SEARCH, 17'd50119, 7'd0);
    send_request(OP_SEARCH, 17'd50001, 7'd0);

    // Random phases with different flow control; the first one also backs the block up.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (phase == 0) hold_start <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end
    in_req.valid <= 1'b0;

    // Let every outstanding response drain, then give the block time for strays.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
